// ===== sv/mrfb_pkg.sv =====
`timescale 1ns / 1ps

package mrfb_pkg;

    localparam int MAX_WRITE_REGS = 123;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
    localparam logic [7:0] FC_WRITE_REG   = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    typedef enum logic [1:0] {
        CMD_ERROR,
        CMD_HEADER,
        CMD_WORD
    } cmd_kind_t;

    // One classified request as handed from the front to the back.
    typedef struct packed {
        cmd_kind_t   kind;
        logic        tcp;
        logic        multi;
        logic        close;
        logic [7:0]  tid;
        logic [7:0]  dev;
        logic [7:0]  fc;
        logic [15:0] reg_addr;
        logic [15:0] word;
        logic [7:0]  blen;
    } cmd_t;

endpackage

// ===== sv/mrfb_front.sv =====
`timescale 1ns / 1ps

module mrfb_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               op,
    input  logic [7:0]         dev_addr,
    input  logic [7:0]         func_code,
    input  logic [15:0]        reg_addr,
    input  logic [7:0]         byte_len,
    input  logic [15:0]        value16,
    input  logic               use_tcp,
    output logic               push,
    output mrfb_pkg::cmd_t     push_cmd
);

    logic [7:0] tid_reg;
    logic [7:0] tid_next;
    logic [6:0] words_left_reg;
    logic [6:0] words_left_next;
    logic       tcp_reg;
    logic       tcp_next;

    logic known;
    logic multi;
    logic bad_len;

    always_comb
    begin
        known   = (func_code inside {[8'd1:8'd6], mrfb_pkg::FC_WRITE_COILS,
                                     mrfb_pkg::FC_WRITE_REGS});
        multi   = (func_code == mrfb_pkg::FC_WRITE_COILS) ||
                  (func_code == mrfb_pkg::FC_WRITE_REGS);
        bad_len = byte_len[0] ||
                  ({1'b0, byte_len} > 9'(2 * mrfb_pkg::MAX_WRITE_REGS));
    end

    always_comb
    begin
        tid_next        = tid_reg;
        words_left_next = words_left_reg;
        tcp_next        = tcp_reg;
        push            = 1'b0;

        push_cmd          = '0;
        push_cmd.kind     = mrfb_pkg::CMD_ERROR;
        push_cmd.tcp      = tcp_reg;
        push_cmd.tid      = tid_reg;
        push_cmd.dev      = dev_addr;
        push_cmd.fc       = func_code;
        push_cmd.reg_addr = reg_addr;
        push_cmd.blen     = byte_len;
        push_cmd.multi    = multi;
        push_cmd.word     = value16;

        if (accept)
        begin
            if (op == mrfb_pkg::OP_PAYLOAD)
            begin
                // A payload word with no write-multiple pending is dropped.
                if (words_left_reg != '0)
                begin
                    push            = 1'b1;
                    push_cmd.kind   = mrfb_pkg::CMD_WORD;
                    push_cmd.close  = (words_left_reg == 7'd1);
                    words_left_next = words_left_reg - 7'd1;
                end
            end
            else
            begin
                push            = 1'b1;
                words_left_next = '0;
                if (!known || (multi && bad_len))
                begin
                    push_cmd.kind = mrfb_pkg::CMD_ERROR;
                end
                else
                begin
                    push_cmd.kind = mrfb_pkg::CMD_HEADER;
                    push_cmd.tcp  = use_tcp;
                    tcp_next      = use_tcp;
                    if (use_tcp)
                    begin
                        tid_next = tid_reg + 8'd1;
                    end
                    if (!((func_code == mrfb_pkg::FC_WRITE_COIL) ||
                          (func_code == mrfb_pkg::FC_WRITE_REG)))
                    begin
                        push_cmd.word = {9'd0, byte_len[7:1]};
                    end
                    if (multi)
                    begin
                        words_left_next = byte_len[7:1];
                        push_cmd.close  = (byte_len[7:1] == '0);
                    end
                    else
                    begin
                        push_cmd.close = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tid_reg        <= '0;
            words_left_reg <= '0;
            tcp_reg        <= 1'b0;
        end
        else
        begin
            tid_reg        <= tid_next;
            words_left_reg <= words_left_next;
            tcp_reg        <= tcp_next;
        end
    end

endmodule

// ===== sv/mrfb_queue.sv =====
`timescale 1ns / 1ps

module mrfb_queue
#(
    parameter int DEPTH = mrfb_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mrfb_pkg::cmd_t push_cmd,
    input  logic           pop,
    output mrfb_pkg::cmd_t head,
    output logic           valid,
    output logic           full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mrfb_pkg::cmd_t entries_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign head  = entries_reg[rd_ptr_reg];
    assign valid = (count_reg != '0);
    assign full  = (count_reg == CW'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// ===== sv/mrfb_back.sv =====
`timescale 1ns / 1ps

module mrfb_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  mrfb_pkg::cmd_t head,
    input  logic           head_valid,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     frame_byte,
    output logic           frame_last,
    output logic           error
);

    typedef enum logic [4:0] {
        B_TID, B_Z1, B_Z2, B_Z3, B_LENH, B_LENL,
        B_DEV, B_FC, B_REGH, B_REGL, B_WH, B_WL, B_BCNT,
        B_PH, B_PL, B_CRCL, B_CRCH, B_ERR
    } step_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ mrfb_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    mrfb_pkg::cmd_t cur_reg;
    step_t          step_reg;
    step_t          step_next;
    logic           active_reg;
    logic [15:0]    crc_reg;
    logic           out_valid_reg;
    logic [7:0]     byte_reg;
    logic           last_reg;
    logic           err_reg;

    logic        adv;
    logic        is_last;
    logic        crc_en;
    logic [7:0]  cur_byte;
    logic        cur_flag_last;
    logic [8:0]  mbap_len;
    step_t       after_data;
    step_t       start_step;

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign frame_last = last_reg;
    assign error      = err_reg;

    assign adv = active_reg && (!out_valid_reg || !out_stall);
    assign pop = head_valid && (!active_reg || (adv && is_last));

    always_comb
    begin
        mbap_len   = cur_reg.multi ? (9'd7 + {1'b0, cur_reg.blen}) : 9'd6;
        // Where a frame goes once its data bytes are out: RTU adds the CRC.
        after_data = B_CRCL;

        case (head.kind)
            mrfb_pkg::CMD_HEADER: start_step = head.tcp ? B_TID : B_DEV;
            mrfb_pkg::CMD_WORD:   start_step = B_PH;
            default:              start_step = B_ERR;
        endcase

        cur_byte      = 8'd0;
        cur_flag_last = 1'b0;
        is_last       = 1'b0;
        step_next     = step_reg;
        crc_en        = 1'b0;

        case (step_reg)
            B_TID:  begin cur_byte = cur_reg.tid;               step_next = B_Z1;   end
            B_Z1:   begin                                       step_next = B_Z2;   end
            B_Z2:   begin                                       step_next = B_Z3;   end
            B_Z3:   begin                                       step_next = B_LENH; end
            B_LENH: begin cur_byte = {7'd0, mbap_len[8]};       step_next = B_LENL; end
            B_LENL: begin cur_byte = mbap_len[7:0];             step_next = B_DEV;  end
            B_DEV:  begin cur_byte = cur_reg.dev;      crc_en = 1'b1; step_next = B_FC;   end
            B_FC:   begin cur_byte = cur_reg.fc;       crc_en = 1'b1; step_next = B_REGH; end
            B_REGH: begin cur_byte = cur_reg.reg_addr[15:8]; crc_en = 1'b1;
                          step_next = B_REGL; end
            B_REGL: begin cur_byte = cur_reg.reg_addr[7:0];  crc_en = 1'b1;
                          step_next = B_WH; end
            B_WH:   begin cur_byte = cur_reg.word[15:8];     crc_en = 1'b1;
                          step_next = B_WL; end
            B_WL, B_BCNT, B_PL:
            begin
                case (step_reg)
                    B_WL:    cur_byte = cur_reg.word[7:0];
                    B_BCNT:  cur_byte = cur_reg.blen;
                    default: cur_byte = cur_reg.word[7:0];
                endcase
                crc_en = 1'b1;
                if ((step_reg == B_WL) && cur_reg.multi)
                begin
                    step_next = B_BCNT;
                end
                else if (cur_reg.close && !cur_reg.tcp)
                begin
                    step_next = after_data;
                end
                else
                begin
                    is_last       = 1'b1;
                    cur_flag_last = cur_reg.close;
                end
            end
            B_PH:   begin cur_byte = cur_reg.word[15:8]; crc_en = 1'b1; step_next = B_PL; end
            B_CRCL: begin cur_byte = crc_reg[7:0];             step_next = B_CRCH; end
            B_CRCH:
            begin
                cur_byte      = crc_reg[15:8];
                cur_flag_last = 1'b1;
                is_last       = 1'b1;
            end
            default:
            begin
                cur_flag_last = 1'b1;
                is_last       = 1'b1;
            end
        endcase

        if (pop)
        begin
            step_next = start_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (adv)
        begin
            byte_reg <= cur_byte;
            last_reg <= cur_flag_last;
            err_reg  <= (step_reg == B_ERR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= B_ERR;
            active_reg    <= 1'b0;
            crc_reg       <= mrfb_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // The sequence only moves when a byte goes out or a new request starts.
            if (adv || pop)
            begin
                step_reg <= step_next;
            end
            if (pop)
            begin
                active_reg <= 1'b1;
            end
            else if (adv && is_last)
            begin
                active_reg <= 1'b0;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
                // The device address byte opens every RTU checksum afresh.
                if (crc_en && !cur_reg.tcp)
                begin
                    crc_reg <= crc_update((step_reg == B_DEV) ? mrfb_pkg::CRC_INIT
                                                              : crc_reg, cur_byte);
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/modbus_request_frame_builder.sv =====
`timescale 1ns / 1ps

// Builds Modbus master request frames, one byte per output request, in
// transmit order. A header request (op = 0) produces its frame bytes: 1
// byte for a rejected request, 8 or 12 bytes for a plain RTU or TCP read
// or single write (CRC or MBAP header included), up to 13 for a
// write-multiple header in TCP framing. Each payload word (op = 1) gives 2
// bytes, plus 2 for the CRC after the last word of an RTU frame. The output
// stage moves one byte per cycle while out_stall is low; a
// queue of QUEUE_DEPTH classified requests sits ahead of it, so input
// requests keep flowing while bytes are stalled at the output, until it fills.
module modbus_request_frame_builder
#(
    parameter int QUEUE_DEPTH = mrfb_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  dev_addr,
    input  logic [7:0]  func_code,
    input  logic [15:0] reg_addr,
    input  logic [7:0]  byte_len,
    input  logic [15:0] value16,
    input  logic        use_tcp,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        frame_last,
    output logic        error
);

    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    logic           q_full;
    mrfb_pkg::cmd_t q_in;
    mrfb_pkg::cmd_t q_head;

    assign in_stall = q_full;

    mrfb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_valid && !in_stall),
        .op        (op),
        .dev_addr  (dev_addr),
        .func_code (func_code),
        .reg_addr  (reg_addr),
        .byte_len  (byte_len),
        .value16   (value16),
        .use_tcp   (use_tcp),
        .push      (q_push),
        .push_cmd  (q_in)
    );

    mrfb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .pop      (q_pop),
        .head     (q_head),
        .valid    (q_valid),
        .full     (q_full)
    );

    mrfb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (q_valid),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .frame_last (frame_last),
        .error      (error)
    );

    // A rejected request is always a single closing byte of zero.
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error) |-> (frame_last && (frame_byte == 8'd0)))
        else $error("error result without frame_last or with nonzero byte");

    // The front must never write into a full queue.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("push into full request queue");

    // The back only takes a request that is actually there.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty request queue");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam logic [7:0] FC_READ_COILS      = 8'd1;
    localparam logic [7:0] FC_READ_INPUTS     = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
    localparam logic [7:0] FC_READ_INPUT_REGS = 8'd4;
    localparam logic [7:0] FC_BAD_LOW         = 8'd0;
    localparam logic [7:0] FC_BAD_GAP         = 8'd7;
    localparam logic [7:0] FC_BAD_HIGH        = 8'hFF;

    localparam int RANDOM_ITEMS = 500;
    localparam int STUCK_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 64;

    typedef struct {
        logic        op;
        logic [7:0]  dev;
        logic [7:0]  fc;
        logic [15:0] reg_addr;
        logic [7:0]  blen;
        logic [15:0] value;
        logic        tcp;
        logic        hold;
    } request_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       err;
    } frame_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = 1'b0;
    logic [7:0]  dev_addr = 8'd0;
    logic [7:0]  func_code = 8'd0;
    logic [15:0] reg_addr = 16'd0;
    logic [7:0]  byte_len = 8'd0;
    logic [15:0] value16 = 16'd0;
    logic        use_tcp = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic        error;

    request_t    request_queue[$];
    frame_byte_t frame_bytes_due[$];
    request_t    next_req;
    frame_byte_t want;

    // Shadow of the block's framing state.
    logic [7:0]  txn_id = 8'd0;
    logic [15:0] crc_acc = mrfb_pkg::CRC_INIT;
    logic [7:0]  words_pending = 8'd0;
    logic        tcp_frame = 1'b0;

    int  request_total = 0;
    int  stray_total = 0;
    int  requests_taken = 0;
    int  bytes_checked = 0;
    int  frames_closed = 0;
    int  rejects_seen = 0;
    int  mismatch_count = 0;
    int  stuck_cycles = 0;
    int  send_gap = 0;
    int  send_quiet = 0;
    int  stall_left = 0;
    int  stall_quiet = 0;
    bit  in_taken = 1'b0;
    bit  hold_next = 1'b0;
    bit  timed_out = 1'b0;

    modbus_request_frame_builder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .dev_addr   (dev_addr),
        .func_code  (func_code),
        .reg_addr   (reg_addr),
        .byte_len   (byte_len),
        .value16    (value16),
        .use_tcp    (use_tcp),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .frame_last (frame_last),
        .error      (error)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic code_known(input logic [7:0] fc);
        return (fc >= FC_READ_COILS && fc <= mrfb_pkg::FC_WRITE_REG) ||
               fc == mrfb_pkg::FC_WRITE_COILS || fc == mrfb_pkg::FC_WRITE_REGS;
    endfunction

    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] acc;
        acc = c ^ {8'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (acc[0])
                acc = (acc >> 1) ^ mrfb_pkg::CRC_POLY;
            else
                acc = acc >> 1;
        end
        return acc;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(input int roll);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return int'($urandom_range(1, 3));
        else
            return int'($urandom_range(8, 40));
    endfunction

    task automatic push_raw(input logic [7:0] b, input logic last, input logic err);
        frame_byte_t fb;
        fb.data = b;
        fb.last = last;
        fb.err  = err;
        frame_bytes_due.push_back(fb);
    endtask

    task automatic push_data(input logic [7:0] b);
        if (!tcp_frame)
            crc_acc = crc_next(crc_acc, b);
        push_raw(b, 1'b0, 1'b0);
    endtask

    task automatic close_frame();
        if (tcp_frame)
            frame_bytes_due[frame_bytes_due.size() - 1].last = 1'b1;
        else
        begin
            push_raw(crc_acc[7:0], 1'b0, 1'b0);
            push_raw(crc_acc[15:8], 1'b1, 1'b0);
        end
    endtask

    task automatic predict_frame_bytes(input request_t rq);
        logic        multi;
        logic [15:0] word;
        logic [15:0] mbap_len;
        if (rq.op == mrfb_pkg::OP_PAYLOAD)
        begin
            if (words_pending == 0)
                return;
            push_data(rq.value[15:8]);
            push_data(rq.value[7:0]);
            words_pending = words_pending - 8'd1;
            if (words_pending == 0)
                close_frame();
            return;
        end
        words_pending = 8'd0;
        multi = (rq.fc == mrfb_pkg::FC_WRITE_COILS || rq.fc == mrfb_pkg::FC_WRITE_REGS);
        if (!code_known(rq.fc) ||
            (multi && (rq.blen[0] || rq.blen > 2 * mrfb_pkg::MAX_WRITE_REGS)))
        begin
            push_raw(8'd0, 1'b1, 1'b1);
            return;
        end
        tcp_frame = rq.tcp;
        crc_acc = mrfb_pkg::CRC_INIT;
        if (rq.tcp)
        begin
            mbap_len = multi ? 16'd7 + {8'd0, rq.blen} : 16'd6;
            push_raw(txn_id, 1'b0, 1'b0);
            push_raw(8'd0, 1'b0, 1'b0);
            push_raw(8'd0, 1'b0, 1'b0);
            push_raw(8'd0, 1'b0, 1'b0);
            push_raw(mbap_len[15:8], 1'b0, 1'b0);
            push_raw(mbap_len[7:0], 1'b0, 1'b0);
            txn_id = txn_id + 8'd1;
        end
        word = (rq.fc == mrfb_pkg::FC_WRITE_COIL || rq.fc == mrfb_pkg::FC_WRITE_REG)
               ? rq.value : {9'd0, rq.blen[7:1]};
        push_data(rq.dev);
        push_data(rq.fc);
        push_data(rq.reg_addr[15:8]);
        push_data(rq.reg_addr[7:0]);
        push_data(word[15:8]);
        push_data(word[7:0]);
        if (multi)
        begin
            push_data(rq.blen);
            words_pending = {1'b0, rq.blen[7:1]};
        end
        if (words_pending == 0)
            close_frame();
    endtask

    task automatic add_request(input logic o, input logic [7:0] dev, input logic [7:0] fc,
                               input logic [15:0] ra, input logic [7:0] blen,
                               input logic [15:0] val, input logic tcp);
        request_t rq;
        rq.op       = o;
        rq.dev      = dev;
        rq.fc       = fc;
        rq.reg_addr = ra;
        rq.blen     = blen;
        rq.value    = val;
        rq.tcp      = tcp;
        rq.hold     = hold_next;
        hold_next   = 1'b0;
        request_queue.push_back(rq);
        request_total++;
    endtask

    // Write-multiple header followed by sent payload words (sent < words breaks the frame).
    task automatic add_write(input logic [7:0] fc, input logic tcp, input int words,
                             input int sent);
        add_request(mrfb_pkg::OP_HEADER, 8'($urandom_range(0, 255)), fc,
                    16'($urandom_range(0, 65535)), 8'(2 * words),
                    16'($urandom_range(0, 65535)), tcp);
        for (int i = 0; i < sent; i++)
            add_request(mrfb_pkg::OP_PAYLOAD, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                        8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                        1'($urandom_range(0, 1)));
    endtask

    // Sender: new fields only once the current request has been taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && !in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (request_queue.size() != 0 &&
                     !(request_queue[0].hold && frame_bytes_due.size() != 0))
            begin
                next_req = request_queue.pop_front();
                op        <= next_req.op;
                dev_addr  <= next_req.dev;
                func_code <= next_req.fc;
                reg_addr  <= next_req.reg_addr;
                byte_len  <= next_req.blen;
                value16   <= next_req.value;
                use_tcp   <= next_req.tcp;
                in_valid  <= 1'b1;
                if (send_quiet > 0)
                begin
                    send_quiet--;
                    send_gap = 0;
                end
                else
                begin
                    send_gap = pick_gap(int'($urandom_range(0, 99)));
                    if ($urandom_range(0, 39) == 0)
                        send_quiet = int'($urandom_range(10, 40));
                end
            end
            else
                in_valid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    // Receiver stall pattern.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (stall_quiet > 0)
                stall_quiet--;
            else if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap(int'($urandom_range(0, 99)));
            if ($urandom_range(0, 49) == 0)
                stall_quiet = int'($urandom_range(20, 60));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                next_req.op       = op;
                next_req.dev      = dev_addr;
                next_req.fc       = func_code;
                next_req.reg_addr = reg_addr;
                next_req.blen     = byte_len;
                next_req.value    = value16;
                next_req.tcp      = use_tcp;
                next_req.hold     = 1'b0;
                predict_frame_bytes(next_req);
                in_taken = 1'b1;
                requests_taken++;
            end
            if (out_valid && !out_stall)
            begin
                bytes_checked++;
                if (frame_bytes_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected frame byte %02h last %0b error %0b",
                             $time, frame_byte, frame_last, error);
                end
                else
                begin
                    want = frame_bytes_due.pop_front();
                    if (frame_byte !== want.data || frame_last !== want.last ||
                        error !== want.err)
                    begin
                        mismatch_count++;
                        $display("%0t: expected byte %02h last %0b error %0b, got %02h %0b %0b",
                                 $time, want.data, want.last, want.err,
                                 frame_byte, frame_last, error);
                    end
                    if (want.err)
                        rejects_seen++;
                    else if (want.last)
                        frames_closed++;
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
    end

    initial
    begin
        int words;
        int sent;
        int roll;
        logic [7:0] fc;
        logic [7:0] blen;

        add_request(mrfb_pkg::OP_HEADER, 8'h00, FC_READ_HOLDING, 16'h0000, 8'd0, 16'h0000,
                    1'b0);
        add_request(mrfb_pkg::OP_HEADER, 8'hFF, FC_READ_COILS, 16'hFFFF, 8'hFF, 16'hFFFF,
                    1'b1);
        add_request(mrfb_pkg::OP_HEADER, 8'h11, FC_READ_INPUTS, 16'h1234, 8'd20, 16'h0000,
                    1'b0);
        add_request(mrfb_pkg::OP_HEADER, 8'h22, FC_READ_INPUT_REGS, 16'h8000, 8'd2, 16'h0000,
                    1'b1);
        add_request(mrfb_pkg::OP_HEADER, 8'h01, mrfb_pkg::FC_WRITE_COIL, 16'h00AC, 8'd0,
                    16'hFF00, 1'b0);
        add_request(mrfb_pkg::OP_HEADER, 8'h02, mrfb_pkg::FC_WRITE_REG, 16'h0001, 8'hFF,
                    16'h0000, 1'b1);
        add_request(mrfb_pkg::OP_HEADER, 8'h03, mrfb_pkg::FC_WRITE_REG, 16'h5555, 8'd0,
                    16'hFFFF, 1'b0);
        add_request(mrfb_pkg::OP_HEADER, 8'h04, mrfb_pkg::FC_WRITE_REGS, 16'h0010, 8'd4,
                    16'h0000, 1'b0);
        add_request(mrfb_pkg::OP_PAYLOAD, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1);
        add_request(mrfb_pkg::OP_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 16'h0000, 1'b0);
        add_request(mrfb_pkg::OP_HEADER, 8'h05, mrfb_pkg::FC_WRITE_COILS, 16'h0020, 8'd2,
                    16'h0000, 1'b1);
        add_request(mrfb_pkg::OP_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 16'hA5A5, 1'b0);
        // Write-multiple with no words closes after the byte count, plus the CRC in RTU.
        add_request(mrfb_pkg::OP_HEADER, 8'h06, mrfb_pkg::FC_WRITE_REGS, 16'h0030, 8'd0,
                    16'h0000, 1'b0);
        add_request(mrfb_pkg::OP_HEADER, 8'h07, mrfb_pkg::FC_WRITE_COILS, 16'h0040, 8'd0,
                    16'h0000, 1'b1);
        // A payload word with no frame open is dropped.
        add_request(mrfb_pkg::OP_PAYLOAD, 8'h08, 8'h00, 16'h0000, 8'h00, 16'h1357, 1'b0);
        add_request(mrfb_pkg::OP_HEADER, 8'h09, FC_BAD_LOW, 16'h0000, 8'd0, 16'h0000, 1'b0);
        add_request(mrfb_pkg::OP_HEADER, 8'h0A, FC_BAD_GAP, 16'h0000, 8'd0, 16'h0000, 1'b1);
        add_request(mrfb_pkg::OP_HEADER, 8'h0B, FC_BAD_HIGH, 16'h0000, 8'd0, 16'h0000, 1'b0);
        add_request(mrfb_pkg::OP_HEADER, 8'h0C, mrfb_pkg::FC_WRITE_REGS, 16'h0000, 8'd3,
                    16'h0000, 1'b0);
        add_request(mrfb_pkg::OP_HEADER, 8'h0D, mrfb_pkg::FC_WRITE_COILS, 16'h0000, 8'd248,
                    16'h0000, 1'b1);
        // Largest legal write, abandoned by a new header after one word.
        add_request(mrfb_pkg::OP_HEADER, 8'h0E, mrfb_pkg::FC_WRITE_REGS, 16'h0100,
                    8'(2 * mrfb_pkg::MAX_WRITE_REGS), 16'h0000, 1'b1);
        add_request(mrfb_pkg::OP_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 16'h1234, 1'b1);
        add_request(mrfb_pkg::OP_HEADER, 8'h0F, FC_READ_HOLDING, 16'h0200, 8'd8, 16'h0000,
                    1'b0);
        add_request(mrfb_pkg::OP_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 16'h4321, 1'b0);
        // A rejected header also drops the open frame.
        add_request(mrfb_pkg::OP_HEADER, 8'h10, mrfb_pkg::FC_WRITE_COILS, 16'h0300, 8'd4,
                    16'h0000, 1'b0);
        add_request(mrfb_pkg::OP_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 16'h0F0F, 1'b0);
        add_request(mrfb_pkg::OP_HEADER, 8'h11, FC_BAD_GAP, 16'h0000, 8'd0, 16'h0000, 1'b0);
        add_request(mrfb_pkg::OP_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 16'hF0F0, 1'b0);
        stray_total = 3;

        hold_next = 1'b1;
        while (request_total - stray_total < RANDOM_ITEMS + 28)
        begin
            if ($urandom_range(0, 59) == 0)
                hold_next = 1'b1;
            roll = int'($urandom_range(0, 99));
            if (roll < 45)
            begin
                fc = 8'($urandom_range(FC_READ_COILS, mrfb_pkg::FC_WRITE_REG));
                add_request(mrfb_pkg::OP_HEADER, 8'($urandom_range(0, 255)), fc,
                            16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            end
            else if (roll < 80)
            begin
                fc = $urandom_range(0, 1) ? mrfb_pkg::FC_WRITE_REGS : mrfb_pkg::FC_WRITE_COILS;
                roll = int'($urandom_range(0, 39));
                if (roll == 0)
                    words = mrfb_pkg::MAX_WRITE_REGS;
                else if (roll < 8)
                    words = int'($urandom_range(0, 1));
                else
                    words = int'($urandom_range(2, 8));
                sent = words;
                if (words > 0 && $urandom_range(0, 9) == 0)
                    sent = int'($urandom_range(0, words - 1));
                add_write(fc, 1'($urandom_range(0, 1)), words, sent);
            end
            else if (roll < 90)
            begin
                if ($urandom_range(0, 1))
                begin
                    fc = 8'($urandom_range(0, 255));
                    while (code_known(fc))
                        fc = 8'($urandom_range(0, 255));
                    blen = 8'($urandom_range(0, 255));
                end
                else
                begin
                    fc = $urandom_range(0, 1) ? mrfb_pkg::FC_WRITE_REGS
                                              : mrfb_pkg::FC_WRITE_COILS;
                    if ($urandom_range(0, 1))
                        blen = 8'($urandom_range(0, 127) * 2 + 1);
                    else
                        blen = 8'($urandom_range(mrfb_pkg::MAX_WRITE_REGS + 1, 127) * 2);
                end
                add_request(mrfb_pkg::OP_HEADER, 8'($urandom_range(0, 255)), fc,
                            16'($urandom_range(0, 65535)), blen,
                            16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                add_request(mrfb_pkg::OP_PAYLOAD, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                            8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                            1'($urandom_range(0, 1)));
                stray_total++;
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (!timed_out && (requests_taken < request_total || frame_bytes_due.size() != 0))
        begin
            @(negedge clk);
            if (stuck_cycles >= STUCK_LIMIT)
                timed_out = 1'b1;
        end
        if (!timed_out)
            repeat (TAIL_CYCLES) @(negedge clk);

        $display("Sent %0d requests over RTU and TCP framing and checked %0d frame bytes.",
                 requests_taken, bytes_checked);
        $display("That made %0d complete frames and %0d rejected requests; %0d mismatches.",
                 frames_closed, rejects_seen, mismatch_count);
        if (timed_out || mismatch_count != 0 || frame_bytes_due.size() != 0)
            $display("testbench failed");
        else
            $display("testbench passed");
        $finish;
    end

endmodule
